>>> rtl/u2u8_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps

package u2u8_pkg;

	localparam logic [15:0] SUR_MASK      = 16'hFC00;
	localparam logic [15:0] SUR_HIGH      = 16'hD800;
	localparam logic [15:0] ONE_BYTE_MASK = 16'hFF80;
	localparam logic [15:0] TWO_BYTE_MASK = 16'hF800;
	localparam logic [20:0] SUPP_OFFSET   = 21'h10000;

	// Length of a UTF-8 sequence, coded as the index of its last byte.
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} len_t;

	// One classified code point waiting to be serialised.
	typedef struct packed {
		logic [20:0] scalar;
		len_t        len;
	} entry_t;

	// Write side of the queue between front and back.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

>>> rtl/u2u8_front.sv
// Front end: accepts code units, pairs surrogates and classifies sequence length.
`timescale 1ns / 1ps

module u2u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        code_unit,
	input  logic               queue_full,
	output u2u8_pkg::push_t    push
);

	logic       pending_q;
	logic [9:0] high_bits_q;
	logic       accept;
	logic       is_high;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign is_high  = (code_unit & u2u8_pkg::SUR_MASK) == u2u8_pkg::SUR_HIGH;

	always_comb begin
		push.valid        = accept;
		push.entry.scalar = {5'd0, code_unit};
		push.entry.len    = u2u8_pkg::LEN_3;
		if (pending_q) begin
			push.entry.scalar = {1'b0, high_bits_q, code_unit[9:0]} + u2u8_pkg::SUPP_OFFSET;
			push.entry.len    = u2u8_pkg::LEN_4;
		end else if ((code_unit & u2u8_pkg::ONE_BYTE_MASK) == 16'd0) begin
			push.entry.len = u2u8_pkg::LEN_1;
		end else if ((code_unit & u2u8_pkg::TWO_BYTE_MASK) == 16'd0) begin
			push.entry.len = u2u8_pkg::LEN_2;
		end else if (is_high) begin
			push.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			high_bits_q <= 10'd0;
		end else if (accept) begin
			if (pending_q) begin
				pending_q   <= 1'b0;
				high_bits_q <= 10'd0;
			end else if (is_high) begin
				pending_q   <= 1'b1;
				high_bits_q <= code_unit[9:0];
			end
		end
	end

endmodule

>>> rtl/u2u8_queue.sv
// Small first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps

module u2u8_queue #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty     = count_q == CNT_W'(0);
	assign full      = count_q == CNT_W'(DEPTH);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/u2u8_back.sv
// Back end: serialises queued code points into UTF-8 bytes behind an output register.
`timescale 1ns / 1ps

module u2u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u2u8_pkg::entry_t   head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       is_last;
	logic [1:0] shift;
	logic [5:0] chunk;
	logic [7:0] next_byte;

	assign load    = head_valid && (!valid_q || out_ready);
	assign is_last = idx_q == head.len;
	assign pop     = load && is_last;
	assign shift   = head.len - idx_q;

	always_comb begin
		unique case (shift)
			2'd0: chunk = head.scalar[5:0];
			2'd1: chunk = head.scalar[11:6];
			2'd2: chunk = head.scalar[17:12];
			2'd3: chunk = {3'd0, head.scalar[20:18]};
			default: chunk = head.scalar[5:0];
		endcase
		if (idx_q != 2'd0) begin
			next_byte = {2'b10, chunk};
		end else begin
			unique case (head.len)
				u2u8_pkg::LEN_1: next_byte = head.scalar[7:0];
				u2u8_pkg::LEN_2: next_byte = {3'b110, chunk[4:0]};
				u2u8_pkg::LEN_3: next_byte = {4'b1110, chunk[3:0]};
				u2u8_pkg::LEN_4: next_byte = {5'b11110, chunk[2:0]};
				default: next_byte = head.scalar[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

>>> rtl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps

// Takes one UTF-16 code unit per input item and gives its UTF-8 bytes, one byte per output
// item, with tlast on the final byte of each code point. The output side runs at one byte per
// cycle while m_axis_tready is high and bytes are waiting; a code unit gives one to three bytes
// and a surrogate pair four, while a high surrogate on its own gives no byte. A queue of
// QUEUE_DEPTH classified code points lets input be taken while earlier bytes are still being
// sent. The unit after a high surrogate is always used as its low half.
module utf16_to_utf8_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast
);

	localparam int ENTRY_W = $bits(u2u8_pkg::entry_t);

	u2u8_pkg::push_t  push;
	u2u8_pkg::entry_t head;
	logic             queue_full;
	logic             queue_empty;
	logic             pop;

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.code_unit  (s_axis_tdata),
		.queue_full (queue_full),
		.push       (push)
	);

	u2u8_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push.valid),
		.push_data (push.entry),
		.pop       (pop),
		.head_data (head),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!queue_empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
